@@ design/dtq_pkg.sv @@
package dtq_pkg;

	// Depths of the two internal queues.
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_TONE_LENGTH = 2'd0;
	localparam cfg_index_t CFG_FADE_LENGTH = 2'd1;
	localparam cfg_index_t CFG_FADE_STEP   = 2'd2;
	localparam logic [16:0] FADE_STEP_RESET = 17'd819;

	// Input item modes.
	localparam logic MODE_MIC = 1'b0;
	localparam logic MODE_KEY = 1'b1;

	// Tone arithmetic.
	localparam int ROM_W     = 14;
	localparam int TONE_PEAK = 11468;
	localparam logic [16:0] GAIN_FULL = 17'd65536;
	localparam logic signed [17:0] SAT_HI = 18'sd32767;
	localparam logic signed [17:0] SAT_LO = -18'sd32767;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] mic_sample;
		logic [7:0]         digit_char;
	} in_item_t;

	typedef struct packed {
		logic               sample_valid;
		logic signed [15:0] mixed_sample;
		logic               tone_valid;
		logic signed [15:0] tone_sample;
		logic               digit_dropped;
		logic               tone_busy;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_MIC,
		KIND_KEY,
		KIND_OTHER
	} item_kind_t;

	// Classified request handed from the front end to the sequencer.
	typedef struct packed {
		item_kind_t         kind;
		logic signed [15:0] mic;
		logic [3:0]         key;
	} cmd_t;

	// Per-sample control carried alongside the tone datapath.
	typedef struct packed {
		logic               sample_valid;
		logic               tone_valid;
		logic               dropped;
		logic               busy;
		logic signed [15:0] mic;
		logic [15:0]        fade_pos;
	} slot_t;

endpackage

@@ design/dtq_front.sv @@
module dtq_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  dtq_pkg::in_item_t item,
	input  logic             take,
	output logic             cmd_valid,
	output dtq_pkg::cmd_t    cmd
);
	import dtq_pkg::*;

	localparam int PTR_W = $clog2(CMD_DEPTH);

	localparam logic [7:0] CHAR_ONE  = 8'h31;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [3:0] KEY_STAR  = 4'd9;
	localparam logic [3:0] KEY_ZERO  = 4'd10;
	localparam logic [3:0] KEY_HASH  = 4'd11;

	cmd_t             fifo_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             accept;
	logic [4:0]       key_info;
	cmd_t             entry;

	// Returns {recognized, key code}; key codes run row by row over the keypad.
	function automatic logic [4:0] classify_key(input logic [7:0] ch);
		logic [7:0] offs;
		logic [4:0] res;
		offs = ch - CHAR_ONE;
		case (ch) inside
			[CHAR_ONE:CHAR_NINE]: res = {1'b1, offs[3:0]};
			CHAR_STAR:            res = {1'b1, KEY_STAR};
			CHAR_ZERO:            res = {1'b1, KEY_ZERO};
			CHAR_HASH:            res = {1'b1, KEY_HASH};
			default:              res = 5'd0;
		endcase
		return res;
	endfunction

	assign full      = (count_q == (PTR_W+1)'(CMD_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_comb begin
		key_info  = classify_key(item.digit_char);
		entry.mic = item.mic_sample;
		entry.key = key_info[3:0];
		if (item.mode == MODE_KEY) begin
			entry.kind = key_info[4] ? KIND_KEY : KIND_OTHER;
		end else begin
			entry.kind = KIND_MIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !accept) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

@@ design/dtq_exec.sv @@
module dtq_exec #(
	parameter int SAMPLE_RATE = 8000,
	parameter int QUEUE_DEPTH = 16,
	parameter int PHASE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  dtq_pkg::cmd_t         cmd,
	input  logic [15:0]           tone_length,
	output logic                  valid_s1,
	output dtq_pkg::slot_t        slot_s1,
	output logic [PHASE_BITS-1:0] low_phase_s1,
	output logic [PHASE_BITS-1:0] high_phase_s1
);
	import dtq_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   DEPTH_W   = (CW+1)'(QUEUE_DEPTH);
	localparam logic [QW-1:0] LAST_HEAD = QW'(QUEUE_DEPTH - 1);

	function automatic logic [63:0] phase_inc(input logic [63:0] hz);
		return ((hz << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
	endfunction

	localparam logic [63:0] ROW_INC [4] = '{
		phase_inc(64'd697), phase_inc(64'd770), phase_inc(64'd852), phase_inc(64'd941)
	};
	localparam logic [63:0] COL_INC [3] = '{
		phase_inc(64'd1209), phase_inc(64'd1336), phase_inc(64'd1477)
	};

	function automatic logic [1:0] key_row(input logic [3:0] key);
		logic [1:0] r;
		case (key)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			4'd6, 4'd7, 4'd8: r = 2'd2;
			default:          r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] key_col(input logic [3:0] key);
		logic [1:0] c;
		case (key)
			4'd0, 4'd3, 4'd6, 4'd9:  c = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10: c = 2'd1;
			default:                 c = 2'd2;
		endcase
		return c;
	endfunction

	// Pending digits and tone state.
	logic [3:0]            queue_mem [QUEUE_DEPTH];
	logic [3:0]            next_key_q;
	logic [QW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	logic                  active_q, active_d;
	logic [1:0]            row_q, row_d;
	logic [1:0]            col_q, col_d;
	logic [15:0]           pos_q, pos_d;
	logic [PHASE_BITS-1:0] low_q, low_d;
	logic [PHASE_BITS-1:0] high_q, high_d;

	logic [PHASE_BITS-1:0] low_inc, high_inc;
	logic [15:0]           len;
	logic [16:0]           pos_next;
	logic                  last;
	logic [15:0]           tail;
	logic [15:0]           fade_pos;
	logic [CW:0]           wr_sum, wr_wrap;
	logic [QW-1:0]         wr_addr;
	logic [QW-1:0]         head_plus;
	logic                  mem_we;
	logic                  start;
	logic [3:0]            start_key;
	slot_t                 slot;

	always_comb begin
		low_inc = ROW_INC[row_q][PHASE_BITS-1:0];
		case (col_q)
			2'd0:    high_inc = COL_INC[0][PHASE_BITS-1:0];
			2'd1:    high_inc = COL_INC[1][PHASE_BITS-1:0];
			default: high_inc = COL_INC[2][PHASE_BITS-1:0];
		endcase
	end

	// Position within the tone and its distance from the nearer end.
	assign len       = (tone_length == '0) ? 16'd1 : tone_length;
	assign pos_next  = {1'b0, pos_q} + 17'd1;
	assign last      = (pos_next >= {1'b0, len});
	assign tail      = last ? 16'd0 : (len - 16'd1 - pos_q);
	assign fade_pos  = (pos_q < tail) ? pos_q : tail;

	assign wr_sum    = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign wr_wrap   = (wr_sum >= DEPTH_W) ? (wr_sum - DEPTH_W) : wr_sum;
	assign wr_addr   = wr_wrap[QW-1:0];
	assign head_plus = (head_q == LAST_HEAD) ? '0 : head_q + 1'b1;

	always_comb begin
		head_d            = head_q;
		count_d           = count_q;
		active_d          = active_q;
		row_d             = row_q;
		col_d             = col_q;
		pos_d             = pos_q;
		low_d             = low_q;
		high_d            = high_q;
		mem_we            = 1'b0;
		start             = 1'b0;
		start_key         = cmd.key;
		slot.sample_valid = 1'b0;
		slot.tone_valid   = 1'b0;
		slot.dropped      = 1'b0;
		slot.mic          = '0;
		slot.fade_pos     = fade_pos;
		if (take) begin
			case (cmd.kind)
				KIND_KEY: begin
					// With no tone playing the queue is always empty, so the
					// digit starts right away without passing through it.
					if (!active_q) begin
						start = 1'b1;
					end else if (count_q == DEPTH_C) begin
						slot.dropped = 1'b1;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				KIND_MIC: begin
					slot.sample_valid = 1'b1;
					slot.mic          = cmd.mic;
					if (active_q) begin
						slot.tone_valid = 1'b1;
						low_d           = low_q + low_inc;
						high_d          = high_q + high_inc;
						if (last) begin
							if (count_q == '0) begin
								active_d = 1'b0;
							end else begin
								start     = 1'b1;
								start_key = next_key_q;
								head_d    = head_plus;
								count_d   = count_q - 1'b1;
							end
						end else begin
							pos_d = pos_next[15:0];
						end
					end
				end
				default: ;
			endcase
		end
		if (start) begin
			active_d = 1'b1;
			row_d    = key_row(start_key);
			col_d    = key_col(start_key);
			pos_d    = '0;
			low_d    = '0;
			high_d   = '0;
		end
		slot.busy = active_d || (count_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			active_q <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			pos_q    <= '0;
			low_q    <= '0;
			high_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			head_q   <= head_d;
			count_q  <= count_d;
			active_q <= active_d;
			row_q    <= row_d;
			col_q    <= col_d;
			pos_q    <= pos_d;
			low_q    <= low_d;
			high_q   <= high_d;
			valid_s1 <= take;
		end
	end

	// The oldest waiting digit is kept ready in next_key_q, with a bypass when
	// the entry at the head is written in the same cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			queue_mem[wr_addr] <= cmd.key;
		end
		if (mem_we && (wr_addr == head_d)) begin
			next_key_q <= cmd.key;
		end else begin
			next_key_q <= queue_mem[head_d];
		end
		if (take) begin
			slot_s1       <= slot;
			low_phase_s1  <= low_q;
			high_phase_s1 <= high_q;
		end
	end

endmodule

@@ design/dtq_synth.sv @@
module dtq_synth #(
	parameter int SINE_ENTRIES = 256,
	parameter int PHASE_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  dtq_pkg::slot_t        slot_s1,
	input  logic [PHASE_BITS-1:0] low_phase_s1,
	input  logic [PHASE_BITS-1:0] high_phase_s1,
	input  logic [11:0]           fade_length,
	input  logic [16:0]           fade_step,
	output logic                  wr_en,
	output dtq_pkg::out_item_t    wr_data,
	output logic [2:0]            inflight
);
	import dtq_pkg::*;

	localparam int AW = $clog2(SINE_ENTRIES + 1);
	localparam int RW = PHASE_BITS - 2;
	localparam logic [AW-1:0] SE_W = AW'(SINE_ENTRIES);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [7] = '{
		64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
	};

	// Quarter-wave entry k, evaluated once per entry during elaboration.
	function automatic logic [ROM_W-1:0] sine_entry(input int k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        scaled;
		logic signed [63:0] acc;
		x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
		x2   = (x * x) >> 30;
		term = x;
		acc  = $signed(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = term / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = 64'sd0;
		end
		if (acc > 64'sd1073741824) begin
			acc = 64'sd1073741824;
		end
		scaled = (64'(TONE_PEAK) * $unsigned(acc) + (64'd1 << 29)) >> 30;
		return scaled[ROM_W-1:0];
	endfunction

	logic [ROM_W-1:0] sine_rom [SINE_ENTRIES+1];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	// Stage 2: table addresses and the raw fade product.
	logic [RW+AW-1:0] low_scaled, high_scaled;
	logic [AW-1:0]    low_idx, high_idx;
	logic [AW-1:0]    low_addr, high_addr;
	logic             valid_s2;
	slot_t            slot_s2;
	logic [AW-1:0]    low_addr_s2, high_addr_s2;
	logic             low_neg_s2, high_neg_s2;
	logic             in_fade_s2;
	logic [32:0]      gprod_s2;

	assign low_scaled  = (RW+AW)'(low_phase_s1[RW-1:0]) * (RW+AW)'(SE_W);
	assign high_scaled = (RW+AW)'(high_phase_s1[RW-1:0]) * (RW+AW)'(SE_W);
	assign low_idx     = low_scaled[RW +: AW];
	assign high_idx    = high_scaled[RW +: AW];
	assign low_addr    = low_phase_s1[RW] ? (SE_W - low_idx) : low_idx;
	assign high_addr   = high_phase_s1[RW] ? (SE_W - high_idx) : high_idx;

	// Stage 3: table data and the clamped gain.
	logic             valid_s3;
	slot_t            slot_s3;
	logic [ROM_W-1:0] low_rom_s3, high_rom_s3;
	logic             low_neg_s3, high_neg_s3;
	logic [16:0]      gain_s3;

	// Stage 4: two-tone sum.
	logic               valid_s4;
	slot_t              slot_s4;
	logic signed [15:0] low_val, high_val;
	logic signed [15:0] sum_s4;
	logic [16:0]        gain_s4;

	// Stage 5: gain times magnitude.
	logic        valid_s5;
	slot_t       slot_s5;
	logic [14:0] sum_mag;
	logic        neg_s5;
	logic [31:0] prod_s5;

	assign low_val  = low_neg_s3 ? -$signed({2'b00, low_rom_s3}) : $signed({2'b00, low_rom_s3});
	assign high_val = high_neg_s3 ? -$signed({2'b00, high_rom_s3})
		: $signed({2'b00, high_rom_s3});
	assign sum_mag  = sum_s4[15] ? 15'(-sum_s4) : sum_s4[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		slot_s2      <= slot_s1;
		low_addr_s2  <= low_addr;
		high_addr_s2 <= high_addr;
		low_neg_s2   <= low_phase_s1[RW+1];
		high_neg_s2  <= high_phase_s1[RW+1];
		in_fade_s2   <= (slot_s1.fade_pos < {4'd0, fade_length});
		gprod_s2     <= 33'(fade_step) * 33'(slot_s1.fade_pos);

		slot_s3      <= slot_s2;
		low_rom_s3   <= sine_rom[low_addr_s2];
		high_rom_s3  <= sine_rom[high_addr_s2];
		low_neg_s3   <= low_neg_s2;
		high_neg_s3  <= high_neg_s2;
		if (in_fade_s2 && (gprod_s2 < 33'(GAIN_FULL))) begin
			gain_s3 <= gprod_s2[16:0];
		end else begin
			gain_s3 <= GAIN_FULL;
		end

		slot_s4      <= slot_s3;
		sum_s4       <= low_val + high_val;
		gain_s4      <= gain_s3;

		slot_s5      <= slot_s4;
		neg_s5       <= sum_s4[15];
		prod_s5      <= {17'd0, sum_mag} * {15'd0, gain_s4};
	end

	// Output stage: sign, saturation and the microphone mix.
	logic signed [17:0] tone_raw, tone_sat;
	logic signed [17:0] mix_raw, mix_sat;

	always_comb begin
		tone_raw = neg_s5 ? -$signed({2'b00, prod_s5[31:16]}) : $signed({2'b00, prod_s5[31:16]});
		if (tone_raw > SAT_HI) begin
			tone_sat = SAT_HI;
		end else if (tone_raw < SAT_LO) begin
			tone_sat = SAT_LO;
		end else begin
			tone_sat = tone_raw;
		end
		mix_raw = 18'(slot_s5.mic) + tone_sat;
		if (mix_raw > SAT_HI) begin
			mix_sat = SAT_HI;
		end else if (mix_raw < SAT_LO) begin
			mix_sat = SAT_LO;
		end else begin
			mix_sat = mix_raw;
		end
		wr_data.sample_valid  = slot_s5.sample_valid;
		wr_data.tone_valid    = slot_s5.tone_valid;
		wr_data.digit_dropped = slot_s5.dropped;
		wr_data.tone_busy     = slot_s5.busy;
		if (slot_s5.tone_valid) begin
			wr_data.mixed_sample = mix_sat[15:0];
			wr_data.tone_sample  = tone_sat[15:0];
		end else begin
			wr_data.mixed_sample = slot_s5.mic;
			wr_data.tone_sample  = '0;
		end
	end

	assign wr_en    = valid_s5;
	assign inflight = 3'(valid_s2) + 3'(valid_s3) + 3'(valid_s4) + 3'(valid_s5);

endmodule

@@ design/dtq_result_fifo.sv @@
module dtq_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  dtq_pkg::out_item_t wr_data,
	input  logic               pop,
	output logic               empty,
	output dtq_pkg::out_item_t result,
	output logic [$clog2(dtq_pkg::OUT_DEPTH+1)-1:0] count
);
	import dtq_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);

	out_item_t        fifo_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             rd_en;

	assign empty  = (count_q == '0);
	assign rd_en  = pop && !empty;
	assign result = fifo_q[rd_ptr_q];
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/dtmf_tone_queue_mixer.sv @@
// Channel    Handshake                 Payload                      Moves
// input      push / full               item (mode, mic, digit)      one request per item
// result     pop / empty               result (six fields)          one request per item
// config     cfg_valid / cfg_ready     cfg_index, cfg_data          one register write
//
// One item is accepted per cycle while full is low; one result per cycle is delivered for
// every item while pop is high and empty is low, via the command queue, the sequencer and
// the tone datapath (table address, sine table read, sum, gain multiply, mix).
// Reset is asynchronous and clears all control state; no memory needs a clearing pass.
// full rises when the four-entry command queue is full; the sequencer stops issuing
// while the eight-entry result queue plus the items in flight would overflow.
module dtmf_tone_queue_mixer #(
	parameter int SAMPLE_RATE  = 8000,
	parameter int QUEUE_DEPTH  = 16,
	parameter int SINE_ENTRIES = 256,
	parameter int PHASE_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  dtq_pkg::in_item_t                   item,
	output logic                                empty,
	input  logic                                pop,
	output dtq_pkg::out_item_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  dtq_pkg::cfg_index_t                 cfg_index,
	input  logic [dtq_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dtq_pkg::*;

	localparam int OCW = $clog2(OUT_DEPTH + 1);
	localparam int CRW = OCW + 1;

	// Configuration registers. Writes must arrive only while the block is idle; the block
	// itself does not enforce this, and the datapath reads them directly.
	logic [15:0] tone_length_q;
	logic [11:0] fade_length_q;
	logic [16:0] fade_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_length_q <= 16'(SAMPLE_RATE / 4);
			fade_length_q <= 12'(SAMPLE_RATE / 100);
			fade_step_q   <= FADE_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TONE_LENGTH: tone_length_q <= cfg_data[15:0];
				CFG_FADE_LENGTH: fade_length_q <= cfg_data[11:0];
				CFG_FADE_STEP:   fade_step_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each incoming request and queues it.
	logic cmd_valid;
	cmd_t cmd;
	logic take;

	dtq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.take      (take),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// The sequencer owns the digit queue and tone state and issues one item per
	// cycle when the result queue has a free slot for it.
	logic                  valid_s1;
	slot_t                 slot_s1;
	logic [PHASE_BITS-1:0] low_phase_s1;
	logic [PHASE_BITS-1:0] high_phase_s1;
	logic [2:0]            inflight;
	logic [OCW-1:0]        out_count;
	logic [CRW-1:0]        committed;

	assign committed = CRW'(out_count) + CRW'(valid_s1) + CRW'(inflight);
	assign take      = cmd_valid && (committed < CRW'(OUT_DEPTH));

	dtq_exec #(
		.SAMPLE_RATE (SAMPLE_RATE),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PHASE_BITS  (PHASE_BITS)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.cmd           (cmd),
		.tone_length   (tone_length_q),
		.valid_s1      (valid_s1),
		.slot_s1       (slot_s1),
		.low_phase_s1  (low_phase_s1),
		.high_phase_s1 (high_phase_s1)
	);

	// The tone datapath turns phases and fade position into the mixed sample.
	logic      wr_en;
	out_item_t wr_data;

	dtq_synth #(
		.SINE_ENTRIES (SINE_ENTRIES),
		.PHASE_BITS   (PHASE_BITS)
	) u_synth (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.slot_s1       (slot_s1),
		.low_phase_s1  (low_phase_s1),
		.high_phase_s1 (high_phase_s1),
		.fade_length   (fade_length_q),
		.fade_step     (fade_step_q),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.inflight      (inflight)
	);

	// Finished results wait here until the consumer pops them.
	dtq_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.pop     (pop),
		.empty   (empty),
		.result  (result),
		.count   (out_count)
	);

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the DTMF tone queue and mixer. Requests go in through the
// push/full queue port and results come back through the pop/empty port, one result
// for every request. A model of the keypad queue, the two phase accumulators, the
// quarter-wave sine table and the fade ramp, kept inside this module, predicts each
// result at the moment its request is accepted. The monitor compares every popped
// result field by field against the oldest prediction.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dtq_pkg::*;

	typedef longint unsigned u64_t;

	// Receiver back-pressure styles; the receiver switches between them at random.
	typedef enum int {
		POP_ALWAYS,
		POP_COIN,
		POP_SPARSE
	} pop_style_t;

	// One row of the opening stimulus plan: either a register write or a request,
	// with an optional hand-written expectation.
	typedef struct {
		bit                    is_write;
		cfg_index_t            reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		in_item_t              req;
		bit                    typed;
		out_item_t             want;
	} plan_row_t;

	localparam int          KEY_SLOTS        = 16;
	localparam int          ROM_LAST         = 256;
	localparam u64_t        QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int unsigned AUDIO_RATE       = 8000;
	localparam int unsigned ROW_HZ [4]       = '{697, 770, 852, 941};
	localparam int unsigned COL_HZ [3]       = '{1209, 1336, 1477};
	localparam int          GAIN_ONE         = 65536;
	localparam int          CLIP_LEVEL       = 32767;
	localparam string       KEYPAD           = "0123456789*#";
	localparam int          TARGET_ITEMS     = 1150;
	localparam int          CYCLE_LIMIT      = 400000;
	localparam int          LONG_HOLD        = 400;
	// Idle cycles waited after the last expected result, before the verdict.
	localparam int          PIPE_SLACK       = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              item;
	logic                  empty;
	logic                  pop;
	out_item_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dtmf_tone_queue_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted results waiting for the block to deliver them, oldest first.
	out_item_t mix_expected [$];
	int        mismatch_count = 0;
	int        cycle_count    = 0;

	// Sender pacing and the one-shot request for a long receiver hold-off.
	bit        gaps_on    = 1'b1;
	int        burst_left = 0;
	bit        hold_req   = 1'b0;

	// Mirror of the block's keypad queue, tone generator and registers.
	int        sine_rom [ROM_LAST+1];
	u64_t      row_step [4];
	u64_t      col_step [3];
	logic [3:0]  key_fifo [KEY_SLOTS];
	logic [3:0]  fifo_head;
	logic [4:0]  fifo_count;
	bit          playing;
	int          tone_row;
	int          tone_col;
	logic [15:0] tone_pos;
	logic [31:0] low_acc;
	logic [31:0] high_acc;
	logic [16:0] gain_now;
	logic [15:0] tone_len;
	logic [11:0] fade_len;
	logic [16:0] fade_step;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is bounded no matter what the block does.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Sine of a Q30 angle from the odd Taylor terms through x^13, clamped to [0, 1].
	function automatic longint taylor_sine(u64_t x);
		u64_t   x2;
		u64_t   term;
		longint acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = term / u64_t'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sd1073741824) acc = 64'sd1073741824;
		return acc;
	endfunction

	// Fills the quarter-wave table and the per-sample phase increments, and puts the
	// tone state and the registers at their reset values.
	function automatic void reset_tone_model();
		u64_t x;
		u64_t s;
		for (int k = 0; k <= ROM_LAST; k++) begin
			x = (QUARTER_TURN_Q30 * u64_t'(k) + ROM_LAST / 2) / ROM_LAST;
			s = u64_t'(taylor_sine(x));
			sine_rom[k] = int'((u64_t'(TONE_PEAK) * s + (64'd1 << 29)) >> 30);
		end
		for (int i = 0; i < 4; i++)
			row_step[i] = ((u64_t'(ROW_HZ[i]) << 32) + AUDIO_RATE / 2) / AUDIO_RATE;
		for (int i = 0; i < 3; i++)
			col_step[i] = ((u64_t'(COL_HZ[i]) << 32) + AUDIO_RATE / 2) / AUDIO_RATE;
		fifo_head = '0;
		fifo_count = '0;
		playing = 1'b0;
		tone_row = 0;
		tone_col = 0;
		tone_pos = '0;
		low_acc = '0;
		high_acc = '0;
		gain_now = '0;
		tone_len = 16'(AUDIO_RATE / 4);
		fade_len = 12'(AUDIO_RATE / 100);
		fade_step = FADE_STEP_RESET;
	endfunction

	// Table read: top two phase bits pick the quadrant, the next eight the entry.
	function automatic int rom_read(logic [31:0] ph);
		int v;
		v = ph[30] ? sine_rom[ROM_LAST - int'(ph[29:22])] : sine_rom[ph[29:22]];
		return ph[31] ? -v : v;
	endfunction

	function automatic int key_code(logic [7:0] ch);
		if (ch >= "1" && ch <= "9") return int'(ch) - int'("1");
		if (ch == "*") return 9;
		if (ch == "0") return 10;
		if (ch == "#") return 11;
		return -1;
	endfunction

	function automatic int clip(int v);
		if (v > CLIP_LEVEL) return CLIP_LEVEL;
		if (v < -CLIP_LEVEL) return -CLIP_LEVEL;
		return v;
	endfunction

	// Takes the oldest queued key and restarts both oscillators, or stops the tone.
	function automatic void load_next_key();
		logic [3:0] code;
		if (fifo_count == 0) begin
			playing = 1'b0;
			return;
		end
		code = key_fifo[fifo_head];
		fifo_head++;
		fifo_count--;
		if (code > 11) code = 11;
		tone_row = code / 3;
		tone_col = code % 3;
		tone_pos = '0;
		low_acc = '0;
		high_acc = '0;
		playing = 1'b1;
	endfunction

	// Predicts the result of one accepted request and advances the model.
	function automatic out_item_t predict_mix(in_item_t req);
		out_item_t   r;
		int          code;
		int unsigned len;
		int unsigned p;
		int unsigned tail;
		int unsigned m;
		int          sum;
		int          mag;
		int          tone;
		u64_t        g;
		r = '0;
		if (req.mode == MODE_KEY) begin
			code = key_code(req.digit_char);
			if (code >= 0) begin
				if (fifo_count >= KEY_SLOTS) begin
					r.digit_dropped = 1'b1;
				end else begin
					key_fifo[4'(fifo_head + fifo_count)] = 4'(code);
					fifo_count++;
				end
				if (!playing) load_next_key();
			end
		end else if (playing) begin
			// A zero length plays as one sample; a length lowered below the current
			// position makes this sample the last one.
			len = (tone_len == 0) ? 1 : tone_len;
			p = tone_pos;
			tail = (p + 1 >= len) ? 0 : len - 1 - p;
			m = (p < tail) ? p : tail;
			sum = rom_read(low_acc) + rom_read(high_acc);
			if (m < fade_len) begin
				g = u64_t'(fade_step) * m;
				gain_now = (g > GAIN_ONE) ? 17'(GAIN_ONE) : 17'(g);
			end else begin
				gain_now = 17'(GAIN_ONE);
			end
			mag = int'((u64_t'(sum < 0 ? -sum : sum) * gain_now) >> 16);
			tone = clip(sum < 0 ? -mag : mag);
			r.sample_valid = 1'b1;
			r.tone_valid = 1'b1;
			r.tone_sample = 16'(tone);
			r.mixed_sample = 16'(clip(int'(req.mic_sample) + tone));
			low_acc = low_acc + 32'(row_step[tone_row]);
			high_acc = high_acc + 32'(col_step[tone_col]);
			if (p + 1 >= len) load_next_key();
			else tone_pos = 16'(p + 1);
		end else begin
			// No tone: the microphone sample goes through untouched, even -32768.
			r.sample_valid = 1'b1;
			r.mixed_sample = req.mic_sample;
		end
		r.tone_busy = playing || (fifo_count != 0);
		return r;
	endfunction

	task automatic compare_field(string fname, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (mix_expected.size() == 0) begin
			$display("%0t: result %h with no request outstanding", $time, got);
			mismatch_count++;
			return;
		end
		want = mix_expected.pop_front();
		compare_field("sample_valid", want.sample_valid, got.sample_valid);
		compare_field("mixed_sample", want.mixed_sample, got.mixed_sample);
		compare_field("tone_valid", want.tone_valid, got.tone_valid);
		compare_field("tone_sample", want.tone_sample, got.tone_sample);
		compare_field("digit_dropped", want.digit_dropped, got.digit_dropped);
		compare_field("tone_busy", want.tone_busy, got.tone_busy);
	endtask

	// Outputs are sampled at the clock edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) check_result(result);
	end

	// The receiver pops on a pattern of its own. Once, when asked, it holds off for a
	// long stretch so that the block backs up all the way to full.
	initial begin
		pop_style_t style;
		int         style_left;
		int         hold_left;
		style = POP_ALWAYS;
		style_left = 0;
		hold_left = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (style_left == 0) begin
				style = pop_style_t'($urandom_range(0, 2));
				style_left = $urandom_range(20, 120);
			end
			style_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (style)
					POP_ALWAYS: pop <= 1'b1;
					POP_COIN:   pop <= 1'($urandom_range(0, 1));
					default:    pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offers one request, waits for it to be taken, and files its expectation. When
	// gaps are on, requests come in bursts with idle stretches in between.
	task automatic send_request(in_item_t req, bit typed, out_item_t want);
		out_item_t predicted;
		if (gaps_on && burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full) @(posedge clk);
		predicted = predict_mix(req);
		mix_expected.push_back(typed ? want : predicted);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic settle();
		push <= 1'b0;
		while (mix_expected.size() != 0) @(posedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid after the last write.
	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_TONE_LENGTH: tone_len = val[15:0];
			CFG_FADE_LENGTH: fade_len = val[11:0];
			CFG_FADE_STEP:   fade_step = val[16:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int tl, int fl, int fs);
		settle();
		write_reg(CFG_TONE_LENGTH, CFG_DATA_W'(tl));
		write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(fl));
		write_reg(CFG_FADE_STEP, CFG_DATA_W'(fs));
		cfg_valid <= 1'b0;
	endtask

	function automatic plan_row_t blank_row();
		plan_row_t r;
		r.is_write = 1'b0;
		r.reg_idx = CFG_TONE_LENGTH;
		r.reg_val = '0;
		r.req = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// A microphone request; when typed, the expectation is a plain pass-through.
	function automatic plan_row_t mic_row(logic signed [15:0] s, bit typed);
		plan_row_t r;
		r = blank_row();
		r.req.mode = MODE_MIC;
		r.req.mic_sample = s;
		r.req.digit_char = 8'hA5;
		r.typed = typed;
		r.want.sample_valid = 1'b1;
		r.want.mixed_sample = s;
		return r;
	endfunction

	// A keypad request; when typed, only the busy flag is set in the expectation.
	function automatic plan_row_t key_row(logic [7:0] ch, bit typed, bit busy);
		plan_row_t r;
		r = blank_row();
		r.req.mode = MODE_KEY;
		r.req.mic_sample = 16'sh5A5A;
		r.req.digit_char = ch;
		r.typed = typed;
		r.want.tone_busy = busy;
		return r;
	endfunction

	function automatic plan_row_t write_row(cfg_index_t idx, int val);
		plan_row_t r;
		r = blank_row();
		r.is_write = 1'b1;
		r.reg_idx = idx;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	initial begin
		plan_row_t opening_plan [$];
		in_item_t  req;
		int        phase;
		int        counted;
		int        n_req;
		int        key_pct;
		int        tl;
		int        fl;
		int        fs;
		int        sel;

		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TONE_LENGTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		reset_tone_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Opening plan. Right after reset nothing plays, so microphone samples pass
		// through and characters outside the keypad leave every field at zero.
		opening_plan.push_back(mic_row(16'sh7FFF, 1'b1));
		opening_plan.push_back(mic_row(-16'sh8000, 1'b1));
		opening_plan.push_back(mic_row(16'sh0000, 1'b1));
		opening_plan.push_back(key_row("A", 1'b1, 1'b0));
		opening_plan.push_back(key_row(8'h00, 1'b1, 1'b0));
		opening_plan.push_back(key_row(8'hFF, 1'b1, 1'b0));
		// The first key starts a tone at once; the rest of the keypad queues behind it.
		opening_plan.push_back(key_row("#", 1'b1, 1'b1));
		for (int i = 0; i < 11; i++)
			opening_plan.push_back(key_row(KEYPAD[i], 1'b1, 1'b1));
		opening_plan.push_back(mic_row(16'sh7FFF, 1'b0));
		opening_plan.push_back(mic_row(-16'sh8000, 1'b0));
		opening_plan.push_back(mic_row(16'sh0000, 1'b0));
		// Shorten the tone under the one that is playing, and drop the fade, so the
		// current tone ends on its next sample and the rest play at full gain.
		opening_plan.push_back(write_row(CFG_TONE_LENGTH, 3));
		opening_plan.push_back(write_row(CFG_FADE_LENGTH, 0));
		opening_plan.push_back(write_row(CFG_FADE_STEP, GAIN_ONE));
		opening_plan.push_back(mic_row(16'sh7FFF, 1'b0));
		opening_plan.push_back(mic_row(-16'sh8000, 1'b0));
		opening_plan.push_back(mic_row(16'sh0000, 1'b0));
		opening_plan.push_back(mic_row(16'sh5555, 1'b0));

		foreach (opening_plan[i]) begin
			if (opening_plan[i].is_write) begin
				settle();
				write_reg(opening_plan[i].reg_idx, opening_plan[i].reg_val);
				if (!(i + 1 < opening_plan.size() && opening_plan[i+1].is_write))
					cfg_valid <= 1'b0;
			end else begin
				send_request(opening_plan[i].req, opening_plan[i].typed,
					opening_plan[i].want);
			end
		end

		// Random phases. The first three pin the register extremes: the longest tone
		// with the longest, slowest fade, then a zero length with no fade and an
		// oversized step, then single-sample tones with a zero step.
		phase = 0;
		counted = 0;
		while (counted < TARGET_ITEMS) begin
			case (phase)
				0: begin tl = 65535; fl = 4095; fs = 16; end
				1: begin tl = 0; fl = 0; fs = 131071; end
				2: begin tl = 1; fl = 4095; fs = 0; end
				default: begin
					sel = $urandom_range(0, 19);
					if (sel == 0) tl = 0;
					else if (sel == 1) tl = 65535;
					else if (sel <= 4) tl = $urandom_range(25, 300);
					else tl = $urandom_range(1, 24);
					sel = $urandom_range(0, 9);
					if (sel == 0) fl = 0;
					else if (sel == 1) fl = 4095;
					else fl = $urandom_range(0, (tl > 8000 ? 4000 : tl / 2 + 1));
					sel = $urandom_range(0, 9);
					if (sel == 0) fs = 0;
					else if (sel == 1) fs = GAIN_ONE;
					else if (sel == 2) fs = 131071;
					else if (sel == 3) fs = $urandom_range(0, 131071);
					else fs = (fl != 0) ? GAIN_ONE / fl : GAIN_ONE;
				end
			endcase
			apply_settings(tl, fl, fs);

			n_req = $urandom_range(30, 90);
			case ($urandom_range(0, 3))
				0: key_pct = 5;
				1: key_pct = 25;
				2: key_pct = 50;
				default: key_pct = 80;
			endcase
			if (phase == 0) key_pct = 50;
			gaps_on = ($urandom_range(0, 3) != 0);
			if (phase == 3) begin
				// Back-to-back requests against a receiver that stops popping.
				gaps_on = 1'b0;
				hold_req = 1'b1;
				n_req = 120;
			end

			for (int i = 0; i < n_req; i++) begin
				req.mic_sample = 16'($urandom);
				sel = $urandom_range(0, 19);
				if (sel == 0) req.mic_sample = 16'sh7FFF;
				else if (sel == 1) req.mic_sample = -16'sh8000;
				else if (sel == 2) req.mic_sample = -16'sh7FFF;
				else if (sel <= 5) req.mic_sample = 16'(int'($urandom_range(0, 400)) - 200);
				req.digit_char = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < key_pct) begin
					req.mode = MODE_KEY;
					if ($urandom_range(0, 99) < 85)
						req.digit_char = KEYPAD[$urandom_range(0, 11)];
				end else begin
					req.mode = MODE_MIC;
				end
				send_request(req, 1'b0, '0);
				if (!(req.mode == MODE_KEY && key_code(req.digit_char) < 0)) counted++;
			end
			phase++;
		end

		settle();
		repeat (PIPE_SLACK) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
